[rtl/utt_pkg.sv]
// shared types, constants and byte encoding for the utf-16 to utf-8 transcoder
package utt_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_W       = 24;
  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned SURR_W      = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] MAX_1B    = 21'h00007F;
  localparam logic [CP_W-1:0] MAX_2B    = 21'h0007FF;
  localparam logic [CP_W-1:0] MAX_3B    = 21'h00FFFF;

  // sequence length minus one
  typedef enum logic [1:0] {
    LEN_1 = 2'd0,
    LEN_2 = 2'd1,
    LEN_3 = 2'd2,
    LEN_4 = 2'd3
  } len_t;

  typedef struct packed {
    logic                   last;
    logic [CP_W-1:0]        cp;
    len_t                   len;
    logic [OUT_COUNT_W-1:0] count;
    logic                   status;
  } rec_t;

  function automatic len_t utt_len(input logic [CP_W-1:0] cp);
    len_t l;
    if (cp <= MAX_1B) begin
      l = LEN_1;
    end else if (cp <= MAX_2B) begin
      l = LEN_2;
    end else if (cp <= MAX_3B) begin
      l = LEN_3;
    end else begin
      l = LEN_4;
    end
    return l;
  endfunction

  function automatic logic [BYTE_W-1:0] utt_byte(input logic [CP_W-1:0] cp, input len_t len,
                                                 input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    unique case (len)
      LEN_1: b = cp[7:0];
      LEN_2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      LEN_3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_4: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[rtl/utt_front.sv]
// front end: takes code units, pairs surrogates, tracks count and capacity, queues code points
module utt_front import utt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              q_full,
  output logic              push,
  output rec_t              push_rec
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned W  = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [CFG_W-1:0]  buffer_size;
  logic [SURR_W-1:0] pending_high, pending_high_next;
  logic              pending_valid, pending_valid_next;
  logic [CW-1:0]     running_count, running_count_next;
  logic              halted, halted_next;
  logic              failed, failed_next;

  logic          accept;
  logic          count_only;
  logic          is_high;
  logic          is_low;
  logic          fail_eff;
  logic          have_cp;
  logic [CP_W-1:0] cp;
  len_t          len;
  logic [W-1:0]  bs_w;
  logic [W-1:0]  max_w;
  logic [W-1:0]  cap_w;
  logic [W-1:0]  rc_w;
  logic [CW-1:0] cap;
  logic [CW:0]   sum;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign count_only = (buffer_size == '0);
  assign is_high    = (code_unit[15:10] == HIGH_SURR_TAG);
  assign is_low     = (code_unit[15:10] == LOW_SURR_TAG);

  assign bs_w  = W'(buffer_size);
  assign max_w = W'({CW{1'b1}});
  assign cap_w = (bs_w < max_w) ? bs_w : max_w;
  assign cap   = cap_w[CW-1:0];
  assign rc_w  = W'(running_count);

  assign len = utt_len(cp);
  assign sum = {1'b0, running_count} + (CW+1)'({1'b0, len} + 3'd1);

  always_comb begin
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    running_count_next = running_count;
    halted_next        = halted;
    failed_next        = failed;
    push               = 1'b0;
    have_cp            = 1'b0;
    cp                 = {{(CP_W-UNIT_W){1'b0}}, code_unit};
    fail_eff           = failed || (pending_valid && !halted);
    push_rec.last      = 1'b0;
    push_rec.cp        = cp;
    push_rec.len       = len;
    push_rec.count     = '0;
    push_rec.status    = 1'b0;
    if (pending_valid) begin
      cp = SUPP_BASE + {1'b0, pending_high, code_unit[9:0]};
      push_rec.cp = cp;
    end
    if (accept) begin
      if (code_unit == '0) begin
        push               = 1'b1;
        push_rec.last      = 1'b1;
        push_rec.count     = fail_eff ? '0 : rc_w[OUT_COUNT_W-1:0];
        push_rec.status    = fail_eff;
        pending_high_next  = '0;
        pending_valid_next = 1'b0;
        running_count_next = CW'(1);
        halted_next        = 1'b0;
        failed_next        = 1'b0;
      end else if (!halted) begin
        if (pending_valid) begin
          pending_valid_next = 1'b0;
          if (!is_low) begin
            failed_next = 1'b1;
            halted_next = 1'b1;
          end else begin
            have_cp = 1'b1;
          end
        end else if (!count_only && running_count >= cap) begin
          halted_next = 1'b1;
        end else if (is_high) begin
          pending_high_next  = code_unit[SURR_W-1:0];
          pending_valid_next = 1'b1;
        end else if (is_low) begin
          failed_next = 1'b1;
          halted_next = 1'b1;
        end else begin
          have_cp = 1'b1;
        end
        if (have_cp) begin
          if (count_only) begin
            running_count_next = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
          end else if (sum > {1'b0, cap}) begin
            halted_next = 1'b1;
          end else begin
            push               = 1'b1;
            running_count_next = sum[CW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size   <= '0;
      pending_high  <= '0;
      pending_valid <= 1'b0;
      running_count <= CW'(1);
      halted        <= 1'b0;
      failed        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        buffer_size <= cfg_data;
      end
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
      running_count <= running_count_next;
      halted        <= halted_next;
      failed        <= failed_next;
    end
  end

endmodule

[rtl/utt_queue.sv]
// short record queue between front and back ends
module utt_queue import utt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic empty,
  output logic full
);

  rec_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;

  assign head  = mem[rd_ptr];
  assign empty = (fill == '0);
  assign full  = (fill == QFILL_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QFILL_W'(1);
        2'b01:   fill <= fill - QFILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_W'(QUEUE_DEPTH))
    else $error("queue fill out of range");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + QFILL_W'(1))
    else $error("queue fill not tracking writes");
`endif

endmodule

[rtl/utt_back.sv]
// back end: expands queued code points into utf-8 bytes through an output register
module utt_back import utt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  rec_t                   head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   last,
  output logic [OUT_COUNT_W-1:0] byte_count,
  output logic                   status
);

  logic [1:0] idx;
  logic       slot_free;
  logic       final_byte;

  assign slot_free  = !out_valid || out_ready;
  assign final_byte = head.last || (idx == head.len);
  assign pop        = slot_free && !empty && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (slot_free) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && !empty) begin
      out_byte   <= head.last ? '0 : utt_byte(head.cp, head.len, idx);
      last       <= head.last;
      byte_count <= head.last ? head.count : '0;
      status     <= head.last && head.status;
    end
  end

`ifndef SYNTHESIS
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (out_byte == '0))
    else $error("end item carries a non-zero byte");
  a_idx_reset: assert property (@(posedge clk) disable iff (rst) pop |=> idx == 2'd0)
    else $error("byte index not cleared after record");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_byte, last, byte_count, status})))
    else $error("output item changed while waiting");
`endif

endmodule

[rtl/utf16_to_utf8_transcoder_core.sv]
// top level of the utf-16 to utf-8 transcoder
// Takes one UTF-16 code unit per cycle while in_ready is high and produces UTF-8 bytes, one
// per cycle while out_ready is high, followed by an end item (zero byte, last set) carrying
// the byte count including terminator and the status (1 on an unpaired surrogate, count
// then zero). A buffer_size of zero counts only. The front end accepts a unit every cycle
// while the four-entry record queue has room, even while the back end still expands earlier
// code points. A unit's first byte goes through the record queue and the output register.
// buffer_size must be written only while the block is idle; the block does not enforce it.
module utf16_to_utf8_transcoder_core import utt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [UNIT_W-1:0]      code_unit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   last,
  output logic [OUT_COUNT_W-1:0] byte_count,
  output logic                   status
);

  logic push;
  rec_t push_rec;
  logic pop;
  rec_t head;
  logic empty;
  logic full;

  utt_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .q_full    (full),
    .push      (push),
    .push_rec  (push_rec)
  );

  utt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  utt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .byte_count (byte_count),
    .status     (status)
  );

endmodule

[tb/utt_tb_pkg.sv]
// scoreboard class for the utf-16 to utf-8 transcoder testbench: utf-8 predictor and byte checker
package utt_tb_pkg;

  localparam int unsigned COUNT_MAX = 32'h00FF_FFFF;

  typedef struct packed {
    logic [7:0]  ob;
    logic        last;
    logic [23:0] count;
    logic        status;
  } utf8_item_t;

  class utf8_scoreboard;
    logic [23:0]  buf_size;
    logic [9:0]   held_high;
    bit           held;
    int unsigned  run_count;
    bit           halted;
    bit           failed;
    utf8_item_t   expected_bytes[$];
    int           errors;

    function new();
      buf_size = '0;
      errors   = 0;
      clear_string();
    endfunction

    function void clear_string();
      held_high = '0;
      held      = 0;
      run_count = 1;
      halted    = 0;
      failed    = 0;
    endfunction

    function void set_buffer_size(logic [23:0] v);
      buf_size = v;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_item(logic [7:0] b, logic l, logic [23:0] c, logic s);
      utf8_item_t it;
      it.ob     = b;
      it.last   = l;
      it.count  = c;
      it.status = s;
      expected_bytes.push_back(it);
    endfunction

    function void fail_string();
      failed = 1;
      halted = 1;
      held   = 0;
    endfunction

    // transcode one accepted code unit into the bytes it should produce
    function void note_unit(logic [15:0] u);
      logic [20:0] cp;
      int unsigned n;
      int unsigned cap;
      bit          count_only;
      cap        = 32'(buf_size);
      count_only = (buf_size == 0);
      if (u == 16'h0000) begin
        if (held && !halted) fail_string();
        push_item(8'h00, 1'b1, failed ? 24'd0 : run_count[23:0], failed);
        clear_string();
        return;
      end
      if (halted) return;
      if (held) begin
        if (u < 16'hDC00 || u > 16'hDFFF) begin
          fail_string();
          return;
        end
        cp   = 21'h10000 + {1'b0, held_high, u[9:0]};
        held = 0;
      end else begin
        if (!count_only && run_count >= cap) begin
          halted = 1;
          return;
        end
        if (u >= 16'hD800 && u <= 16'hDBFF) begin
          held_high = u[9:0];
          held      = 1;
          return;
        end
        if (u >= 16'hDC00 && u <= 16'hDFFF) begin
          fail_string();
          return;
        end
        cp = {5'b0, u};
      end
      if (cp <= 21'h7F) n = 1;
      else if (cp <= 21'h7FF) n = 2;
      else if (cp <= 21'hFFFF) n = 3;
      else n = 4;
      if (count_only) begin
        run_count = (run_count + n > COUNT_MAX) ? COUNT_MAX : run_count + n;
        return;
      end
      if (run_count > cap || cap - run_count < n) begin
        halted = 1;
        return;
      end
      case (n)
        1: push_item({1'b0, cp[6:0]}, 1'b0, 24'd0, 1'b0);
        2: begin
          push_item(8'hC0 | cp[10:6], 1'b0, 24'd0, 1'b0);
          push_item(8'h80 | cp[5:0], 1'b0, 24'd0, 1'b0);
        end
        3: begin
          push_item(8'hE0 | cp[15:12], 1'b0, 24'd0, 1'b0);
          push_item(8'h80 | cp[11:6], 1'b0, 24'd0, 1'b0);
          push_item(8'h80 | cp[5:0], 1'b0, 24'd0, 1'b0);
        end
        default: begin
          push_item(8'hF0 | cp[20:18], 1'b0, 24'd0, 1'b0);
          push_item(8'h80 | cp[17:12], 1'b0, 24'd0, 1'b0);
          push_item(8'h80 | cp[11:6], 1'b0, 24'd0, 1'b0);
          push_item(8'h80 | cp[5:0], 1'b0, 24'd0, 1'b0);
        end
      endcase
      run_count += n;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [7:0] b, logic l, logic [23:0] c, logic s);
      utf8_item_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected item byte=%02h last=%0b count=%0d status=%0b", b, l, c, s));
        return;
      end
      want = expected_bytes.pop_front();
      if (b !== want.ob) report($sformatf("out_byte %02h, want %02h", b, want.ob));
      if (l !== want.last) report($sformatf("last %0b, want %0b", l, want.last));
      if (c !== want.count) report($sformatf("byte_count %0d, want %0d", c, want.count));
      if (s !== want.status) report($sformatf("status %0b, want %0b", s, want.status));
    endtask
  endclass

endpackage

[tb/utf16_to_utf8_transcoder_core_tb.sv]
// top-level testbench for the utf-16 to utf-8 transcoder core
module utf16_to_utf8_transcoder_core_tb;
  import utt_pkg::*;
  import utt_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT  = 200000;
  localparam int SETTLE = 16;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [UNIT_W-1:0]      code_unit  = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [BYTE_W-1:0]      out_byte;
  logic                   last;
  logic [OUT_COUNT_W-1:0] byte_count;
  logic                   status;

  bit             quiet       = 1'b0;
  int             cycle_count = 0;
  utf8_scoreboard sb          = new();

  utf16_to_utf8_transcoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_unit  (code_unit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .byte_count (byte_count),
    .status     (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_byte, last, byte_count, status);
    end
  end

  task automatic send_unit(input logic [UNIT_W-1:0] u);
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= u;
    do @(posedge clk); while (!in_ready);
    sb.note_unit(u);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_buffer_size(v);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic drain();
    wait_empty();
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly well-formed strings, with the odd unpaired surrogate
  task automatic send_random_string(output int sent);
    int          cps;
    int          kind;
    int          i;
    logic [15:0] u;
    sent = 0;
    cps  = $urandom_range(0, 6);
    for (i = 0; i < cps; i++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        u = 16'($urandom_range(1, 127));
        send_unit(u);
        sent++;
      end else if (kind < 50) begin
        u = 16'($urandom_range(128, 2047));
        send_unit(u);
        sent++;
      end else if (kind < 76) begin
        u = 16'($urandom_range(16'h0800, 16'hF7FF));
        if (u >= 16'hD800) u = u + 16'h0800;
        send_unit(u);
        sent++;
      end else if (kind < 96) begin
        u = 16'($urandom_range(16'hD800, 16'hDBFF));
        send_unit(u);
        u = 16'($urandom_range(16'hDC00, 16'hDFFF));
        send_unit(u);
        sent += 2;
      end else begin
        kind = $urandom_range(2);
        if (kind == 0) begin
          u = 16'($urandom_range(16'hDC00, 16'hDFFF));
          send_unit(u);
          sent++;
        end else begin
          u = 16'($urandom_range(16'hD800, 16'hDBFF));
          send_unit(u);
          sent++;
          if (kind == 1) begin
            u = 16'($urandom_range(1, 16'hD7FF));
            send_unit(u);
            sent++;
          end else begin
            break;
          end
        end
      end
    end
    send_unit(16'h0000);
    sent++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int units, input bit calm);
    int n;
    int k;
    int strings;
    drain();
    write_size(size);
    quiet   <= calm;
    n       = 0;
    strings = 0;
    while (n < units) begin
      if (strings == 2 || $urandom_range(7) == 0) wait_empty();
      send_random_string(k);
      n += k;
      strings++;
    end
    drain();
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // count only, every sequence length and a surrogate pair
    write_size(24'd0);
    send_unit(16'h007F); send_unit(16'h0080); send_unit(16'h07FF); send_unit(16'h0800);
    send_unit(16'hFFFF); send_unit(16'hD800); send_unit(16'hDC00); send_unit(16'h0000);
    drain();

    // copy mode with the largest buffer
    write_size(24'hFFFFFF);
    send_unit(16'h0001); send_unit(16'h07FF); send_unit(16'hFFFF);
    send_unit(16'hDBFF); send_unit(16'hDFFF); send_unit(16'h0000);
    // lone low surrogate after an emitted byte, later unit ignored
    send_unit(16'h0041); send_unit(16'hDC00); send_unit(16'h0041); send_unit(16'h0000);
    // high surrogate followed by a plain unit, then by the terminator
    send_unit(16'hD800); send_unit(16'h0041); send_unit(16'h0000);
    send_unit(16'hDBFF); send_unit(16'h0000);
    drain();

    // buffer of one halts at once
    write_size(24'd1);
    send_unit(16'h0041); send_unit(16'h0000);
    drain();

    // code point that does not fit, then a surrogate ignored after the halt
    write_size(24'd4);
    send_unit(16'h0041); send_unit(16'h0800); send_unit(16'hDC00); send_unit(16'h0000);

    run_phase(24'd0, 20, 1'b0);
    run_phase(24'($urandom_range(8, 40)), 24, 1'b0);
    run_phase(24'd1, 8, 1'b0);
    run_phase(24'hFFFFFF, 24, 1'b1);
    run_phase(24'($urandom_range(41, 24'hFFFFFE)), 20, 1'b0);
    run_phase(24'($urandom_range(2, 7)), 12, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
